// ===== rtl/gtf_pkg.sv =====
// Shared types, constants and helper functions of the gradient texel fill unit.
package gtf_pkg;

    localparam int SCALE_BITS  = 16;                 // fraction bits of the blend scale
    localparam int Q_W         = SCALE_BITS + 1;     // scale width, holds 1.0
    localparam int MAX_SIZE    = 1024;               // longest gradient line
    localparam int SIZE_W      = 11;                 // texture size and line index width
    localparam int POS_W       = 10;                 // request coordinate width
    localparam int COLOR_W     = 32;
    localparam int OFF_W       = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int DIV_STEP    = 4;                  // quotient bits per divider stage
    localparam int DIV_STAGES  = (SCALE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int SQ_STAGES   = 4;                  // deepest curve squares four times

    localparam logic [Q_W-1:0] Q_ONE = {1'b1, {SCALE_BITS{1'b0}}};

    // options register bits
    localparam int OPT_WRAP  = 0;
    localparam int OPT_WHOLE = 1;
    localparam int OPT_ALONG = 2;
    localparam int OPT_INTEN = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURVE_KIND = 3'd0,
        CFG_START      = 3'd1,
        CFG_GOAL       = 3'd2,
        CFG_COLOR_FROM = 3'd3,
        CFG_COLOR_TO   = 3'd4,
        CFG_OPTIONS    = 3'd5,
        CFG_TEX_WIDTH  = 3'd6,
        CFG_TEX_HEIGHT = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CURVE_LINEAR = 3'd0,
        CURVE_POW2   = 3'd1,
        CURVE_POW4   = 3'd2,
        CURVE_POW8   = 3'd3,
        CURVE_POW16  = 3'd4,
        CURVE_OUT2   = 3'd5,
        CURVE_OUT4   = 3'd6
    } t_curve;

    typedef enum logic [1:0] {
        SEL_FROM  = 2'd0,
        SEL_TO    = 2'd1,
        SEL_BLEND = 2'd2
    } t_sel;

    typedef struct packed {
        logic             wr;
        logic             inten;
        t_sel             sel;
        logic [OFF_W-1:0] off;
    } t_meta;

    // Number of squarings the curve applies.
    function automatic logic [2:0] curve_squarings(input logic [2:0] kind);
        logic [2:0] n;
        case (kind)
            CURVE_POW2:  n = 3'd1;
            CURVE_POW4:  n = 3'd2;
            CURVE_POW8:  n = 3'd3;
            CURVE_POW16: n = 3'd4;
            CURVE_OUT2:  n = 3'd1;
            CURVE_OUT4:  n = 3'd2;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    // Ease-out curves work on 1-t and flip the result back.
    function automatic logic curve_inverted(input logic [2:0] kind);
        return (kind == CURVE_OUT2) || (kind == CURVE_OUT4);
    endfunction

endpackage

// ===== rtl/gradient_texel_fill_unit.sv =====
// Top level of the gradient texel fill unit: pipelined texel address and color.
//
//  channel  | dir | payload (low bit up)                              | handshake
//  s_axis   | in  | position[9:0] cross_req[19:10]                    | tvalid/tready
//  m_axis   | out | written offset alpha red green blue; tuser=1 byte | tvalid/tready
//  cfg      | in  | i_cfg_index selects register, i_cfg_data value   | valid/ready
//
// Throughput is one transaction per cycle while m_axis is not stalled. The stages
// are the input register, range/offset stage, four restoring-divider stages of
// four quotient bits, curve prep, four squaring stages and the blend/output
// register. The divider and squaring chains set the depth.
// Reset is synchronous, active low: it clears all valid bits and loads the
// register defaults; the config port is always ready. A stall on m_axis freezes
// every stage at once, so s_axis_tready falls in the same cycle and nothing is
// dropped or repeated.
module gradient_texel_fill_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gtf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // position, cross_req, pad
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gtf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // written, offset, alpha,
                                                            // red, green, blue, pad
    output logic                             m_axis_tuser,  // single_byte
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gtf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gtf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SB   = gtf_pkg::SCALE_BITS;
    localparam int QW   = gtf_pkg::Q_W;
    localparam int SW   = gtf_pkg::SIZE_W;
    localparam int PW   = gtf_pkg::POS_W;
    localparam int OW   = gtf_pkg::OFF_W;
    localparam int CW   = gtf_pkg::COLOR_W;
    localparam int DS   = gtf_pkg::DIV_STAGES;
    localparam int DSTP = gtf_pkg::DIV_STEP;
    localparam int QS   = gtf_pkg::SQ_STAGES;
    localparam int BW   = QW + 10;                 // blend accumulator, signed

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]    r_curve_kind;
    logic [SW-1:0] r_start;
    logic [SW-1:0] r_goal;
    logic [CW-1:0] r_color_from;
    logic [CW-1:0] r_color_to;
    logic [3:0]    r_options;
    logic [SW-1:0] r_tex_w;
    logic [SW-1:0] r_tex_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_kind <= gtf_pkg::CURVE_LINEAR;
            r_start      <= '0;
            r_goal       <= '0;
            r_color_from <= '0;
            r_color_to   <= '0;
            r_options    <= '0;
            r_tex_w      <= SW'(8);
            r_tex_h      <= SW'(8);
        end else if (i_cfg_valid) begin
            case (gtf_pkg::t_cfg_idx'(i_cfg_index))
                gtf_pkg::CFG_CURVE_KIND: r_curve_kind <= i_cfg_data[2:0];
                gtf_pkg::CFG_START:      r_start      <= i_cfg_data[SW-1:0];
                gtf_pkg::CFG_GOAL:       r_goal       <= i_cfg_data[SW-1:0];
                gtf_pkg::CFG_COLOR_FROM: r_color_from <= i_cfg_data[CW-1:0];
                gtf_pkg::CFG_COLOR_TO:   r_color_to   <= i_cfg_data[CW-1:0];
                gtf_pkg::CFG_OPTIONS:    r_options    <= i_cfg_data[3:0];
                gtf_pkg::CFG_TEX_WIDTH:  r_tex_w      <= i_cfg_data[SW-1:0];
                gtf_pkg::CFG_TEX_HEIGHT: r_tex_h      <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the whole pipe moves unless the output is held
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_out_valid;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ------------------------------------------------------------------
    // Stage P0: input register
    // ------------------------------------------------------------------
    logic          r_p0_valid;
    logic [PW-1:0] r_p0_pos;
    logic [PW-1:0] r_p0_crs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (w_adv) begin
            r_p0_valid <= s_axis_tvalid;
        end
        if (w_adv) begin
            r_p0_pos <= s_axis_tdata[PW-1:0];
            r_p0_crs <= s_axis_tdata[2*PW-1:PW];
        end
    end

    // ------------------------------------------------------------------
    // Stage P1: write range, wrap, line segment, tiled offset
    // ------------------------------------------------------------------
    logic                r_dv_valid [0:DS];
    gtf_pkg::t_meta      r_dv_meta  [0:DS];
    logic [SB-1:0]       r_dv_q     [0:DS];
    logic [SW-1:0]       r_dv_rem   [0:DS-1];
    logic [SW-1:0]       r_dv_den   [0:DS-1];

    logic [SW-1:0]  len_raw, line_len, across, lo, hi, e_idx;
    logic [PW-1:0]  mid, x, y;
    logic [16:0]    tile_i;
    logic [17:0]    tile_c;
    gtf_pkg::t_meta n_p1_meta;
    logic [SW-1:0]  n_p1_num, n_p1_den;

    always_comb begin
        len_raw  = r_options[gtf_pkg::OPT_ALONG] ? r_tex_h : r_tex_w;
        line_len = (len_raw > SW'(gtf_pkg::MAX_SIZE)) ? SW'(gtf_pkg::MAX_SIZE) : len_raw;
        across   = r_options[gtf_pkg::OPT_ALONG] ? r_tex_w : r_tex_h;
        lo       = r_options[gtf_pkg::OPT_WHOLE] ? '0 : r_start;
        hi       = r_options[gtf_pkg::OPT_WHOLE] ? line_len : r_goal;

        n_p1_meta.wr = ({1'b0, r_p0_pos} >= lo) && ({1'b0, r_p0_pos} < hi)
                    && ({1'b0, r_p0_pos} < line_len) && ({1'b0, r_p0_crs} < across);
        n_p1_meta.inten = r_options[gtf_pkg::OPT_INTEN];

        // rotate the line by half its length
        mid = line_len[SW-1:1];
        if (!r_options[gtf_pkg::OPT_WRAP]) begin
            e_idx = {1'b0, r_p0_pos};
        end else if (r_p0_pos < mid) begin
            e_idx = {1'b0, r_p0_pos} + {1'b0, mid};
        end else begin
            e_idx = {1'b0, r_p0_pos} - {1'b0, mid};
        end

        // goal-1 rule wins over the start rule
        if ((r_goal == '0) || ({1'b0, e_idx} + (SW+1)'(1) >= {1'b0, r_goal})) begin
            n_p1_meta.sel = gtf_pkg::SEL_TO;
        end else if (e_idx <= r_start) begin
            n_p1_meta.sel = gtf_pkg::SEL_FROM;
        end else begin
            n_p1_meta.sel = gtf_pkg::SEL_BLEND;
        end
        n_p1_num = e_idx - r_start;
        n_p1_den = r_goal - r_start;

        // tiled byte offset: 8x4 I8 tiles or 4x4 RGBA8 tiles (AR and GB planes)
        x      = r_options[gtf_pkg::OPT_ALONG] ? r_p0_crs : r_p0_pos;
        y      = r_options[gtf_pkg::OPT_ALONG] ? r_p0_pos : r_p0_crs;
        tile_i = 17'(x[PW-1:3]) + 17'(y[PW-1:2]) * 17'(r_tex_w[SW-1:3]);
        tile_c = 18'(x[PW-1:2]) + 18'(y[PW-1:2]) * 18'(r_tex_w[SW-1:2]);
        if (r_options[gtf_pkg::OPT_INTEN]) begin
            n_p1_meta.off = OW'({tile_i, 5'd0}) + OW'({y[1:0], 3'd0}) + OW'(x[2:0]);
        end else begin
            n_p1_meta.off = OW'({tile_c, 6'd0}) + OW'({y[1:0], 3'd0}) + OW'({x[1:0], 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_valid[0] <= r_p0_valid;
        end
        if (w_adv) begin
            r_dv_meta[0] <= n_p1_meta;
            r_dv_rem[0]  <= n_p1_num;
            r_dv_den[0]  <= n_p1_den;
            r_dv_q[0]    <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: t = (num << SB) / den, DIV_STEP quotient bits each
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [SW-1:0] rem_c;
        logic [SB-1:0] q_c;
        logic [SW:0]   trial;

        always_comb begin
            rem_c = r_dv_rem[k];
            q_c   = r_dv_q[k];
            trial = '0;
            for (int j = 0; j < DSTP; j++) begin
                if (k * DSTP + j < SB) begin
                    trial = {rem_c, 1'b0};
                    if (trial >= {1'b0, r_dv_den[k]}) begin
                        rem_c = SW'(trial - {1'b0, r_dv_den[k]});
                        q_c   = {q_c[SB-2:0], 1'b1};
                    end else begin
                        rem_c = trial[SW-1:0];
                        q_c   = {q_c[SB-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            if (w_adv) begin
                r_dv_meta[k+1] <= r_dv_meta[k];
                r_dv_q[k+1]    <= q_c;
            end
        end

        if (k + 1 < DS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dv_rem[k+1] <= rem_c;
                    r_dv_den[k+1] <= r_dv_den[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Curve prep and squaring stages
    // ------------------------------------------------------------------
    logic           r_sq_valid [0:QS];
    gtf_pkg::t_meta r_sq_meta  [0:QS];
    logic [QW-1:0]  r_sq_v     [0:QS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_valid[0] <= r_dv_valid[DS];
        end
        if (w_adv) begin
            r_sq_meta[0] <= r_dv_meta[DS];
            r_sq_v[0]    <= gtf_pkg::curve_inverted(r_curve_kind)
                          ? gtf_pkg::Q_ONE - {1'b0, r_dv_q[DS]} : {1'b0, r_dv_q[DS]};
        end
    end

    for (genvar j = 1; j <= QS; j++) begin : g_sq
        logic [2*QW-1:0] prod;
        logic [QW-1:0]   v_c;

        always_comb begin
            prod = r_sq_v[j-1] * r_sq_v[j-1];
            v_c  = (3'(j) <= gtf_pkg::curve_squarings(r_curve_kind))
                 ? prod[SB+QW-1:SB] : r_sq_v[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[j] <= 1'b0;
            end else if (w_adv) begin
                r_sq_valid[j] <= r_sq_valid[j-1];
            end
            if (w_adv) begin
                r_sq_meta[j] <= r_sq_meta[j-1];
                r_sq_v[j]    <= v_c;
            end
        end
    end

    // ------------------------------------------------------------------
    // Blend and output register
    // ------------------------------------------------------------------
    logic [QW-1:0]                   scale;
    logic [CW-1:0]                   blend, col;
    logic [7:0]                      ch_a, ch_b;
    logic signed [8:0]               diff;
    logic signed [BW-1:0]            acc;
    logic [gtf_pkg::OUT_TDATA_W-1:0] n_out_data;
    gtf_pkg::t_meta                  mo;
    logic [gtf_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic                            r_out_user;

    always_comb begin
        mo    = r_sq_meta[QS];
        scale = gtf_pkg::curve_inverted(r_curve_kind)
              ? gtf_pkg::Q_ONE - r_sq_v[QS] : r_sq_v[QS];
        blend = '0;
        ch_a  = '0;
        ch_b  = '0;
        diff  = '0;
        acc   = '0;
        for (int c = 0; c < 4; c++) begin
            ch_a = r_color_from[8*c +: 8];
            ch_b = r_color_to[8*c +: 8];
            diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
            acc  = $signed(BW'({ch_a, {SB{1'b0}}})) + $signed({1'b0, scale}) * diff;
            if (acc < 0) begin
                acc = '0;
            end
            blend[8*c +: 8] = acc[SB+7:SB];
        end

        case (mo.sel)
            gtf_pkg::SEL_TO:   col = r_color_to;
            gtf_pkg::SEL_FROM: col = r_color_from;
            default:           col = blend;
        endcase

        n_out_data          = '0;
        n_out_data[0]       = mo.wr;
        n_out_data[22:1]    = mo.wr ? mo.off : '0;
        n_out_data[30:23]   = (mo.wr && !mo.inten) ? col[7:0] : 8'd0;     // alpha
        n_out_data[38:31]   = mo.wr ? col[31:24] : 8'd0;                  // red
        n_out_data[46:39]   = (mo.wr && !mo.inten) ? col[23:16] : 8'd0;   // green
        n_out_data[54:47]   = (mo.wr && !mo.inten) ? col[15:8] : 8'd0;    // blue
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_sq_valid[QS];
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
            r_out_user <= mo.inten;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== rtl/gtf_checker.sv =====
// Port-level checker for the gradient texel fill unit and its bind.
module gtf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [gtf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

    // an empty output register never back-pressures the input
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a texel outside the write range carries no offset and no color
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[54:1] == '0)
        else $error("unwritten texel carries data");

    // intensity format drives only the red byte
    a_inten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser
        |-> m_axis_tdata[30:23] == 8'd0 && m_axis_tdata[54:39] == 16'd0)
        else $error("intensity texel carries color bytes");

    // no result leaves right after reset
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind gradient_texel_fill_unit gtf_checker u_gtf_checker (.*);

// ===== verif/gradient_texel_fill_unit_tb.sv =====
// Self-checking testbench of the gradient texel fill unit: stream driver, monitor and predictor.
module gradient_texel_fill_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = gtf_pkg::DIV_STAGES + gtf_pkg::SQ_STAGES + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;
    localparam int PHASE_ITEMS = 115;
    localparam int SB          = gtf_pkg::SCALE_BITS;
    localparam int PW          = gtf_pkg::POS_W;

    // option masks built from the package bit positions
    localparam logic [3:0] O_WRAP  = 4'b1 << gtf_pkg::OPT_WRAP;
    localparam logic [3:0] O_WHOLE = 4'b1 << gtf_pkg::OPT_WHOLE;
    localparam logic [3:0] O_ALONG = 4'b1 << gtf_pkg::OPT_ALONG;
    localparam logic [3:0] O_INTEN = 4'b1 << gtf_pkg::OPT_INTEN;

    typedef struct {
        logic                      written;
        logic [gtf_pkg::OFF_W-1:0] offset;
        logic [7:0]                alpha;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic                      single_byte;
    } t_texel_result;

    typedef struct {
        logic [PW-1:0] position;
        logic [PW-1:0] cross_req;
    } t_texel_request;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [gtf_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [gtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [gtf_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [gtf_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Shadow copy of the register file, updated on every accepted config transaction.
    logic [2:0]                  sh_curve   = gtf_pkg::CURVE_LINEAR;
    logic [gtf_pkg::SIZE_W-1:0]  sh_start   = '0;
    logic [gtf_pkg::SIZE_W-1:0]  sh_goal    = '0;
    logic [gtf_pkg::COLOR_W-1:0] sh_from    = '0;
    logic [gtf_pkg::COLOR_W-1:0] sh_to      = '0;
    logic [3:0]                  sh_options = '0;
    logic [gtf_pkg::SIZE_W-1:0]  sh_width   = 11'd8;
    logic [gtf_pkg::SIZE_W-1:0]  sh_height  = 11'd8;

    t_texel_request texel_requests[$];   // requests waiting for the stream driver
    t_texel_result  expected_texels[$];  // predicted results, oldest first

    int  issued_items   = 0;
    int  accepted_items = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    logic item_taken    = 1'b0;

    gradient_texel_fill_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q1.16 product, truncated.
    function automatic longint unsigned q_square(input longint unsigned a);
        return (a * a) >> SB;
    endfunction

    function automatic longint unsigned ease_curve(input longint unsigned t);
        longint unsigned one;
        one = 64'd1 << SB;
        case (sh_curve)
            gtf_pkg::CURVE_POW2:  return q_square(t);
            gtf_pkg::CURVE_POW4:  return q_square(q_square(t));
            gtf_pkg::CURVE_POW8:  return q_square(q_square(q_square(t)));
            gtf_pkg::CURVE_POW16: return q_square(q_square(q_square(q_square(t))));
            gtf_pkg::CURVE_OUT2:  return one - q_square(one - t);
            gtf_pkg::CURVE_OUT4:  return one - q_square(q_square(one - t));
            default:              return t;  // linear, and the unused selector seven
        endcase
    endfunction

    // Per-channel blend a + s*(b-a), truncated toward zero, never below zero.
    function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] b,
                                                 input longint unsigned s);
        longint v;
        v = (longint'(a) <<< SB) + longint'(s) * (longint'(b) - longint'(a));
        if (v < 0)
            v = 0;
        return v[SB +: 8];
    endfunction

    // Color of line index e. The goal rule wins over the start rule, so a goal
    // at or below the start (or zero) still yields color_to from goal-1 on.
    function automatic logic [gtf_pkg::COLOR_W-1:0] gradient_color(input longint e);
        longint                      st;
        longint                      gl;
        longint unsigned             t;
        longint unsigned             s;
        logic [gtf_pkg::COLOR_W-1:0] res;
        st = longint'(sh_start);
        gl = longint'(sh_goal);
        if (e >= gl - 1)
            return sh_to;
        if (e <= st)
            return sh_from;
        t = ((e - st) <<< SB) / (gl - st);
        s = ease_curve(t);
        for (int k = 0; k < 4; k++)
            res[8*k +: 8] = blend_channel(sh_from[8*k +: 8], sh_to[8*k +: 8], s);
        return res;
    endfunction

    function automatic t_texel_result predict_texel(input logic [PW-1:0] pos,
                                                    input logic [PW-1:0] crs);
        t_texel_result               r;
        int unsigned                 len, across, lo, hi, mid, x, y, off;
        longint                      e;
        logic [gtf_pkg::COLOR_W-1:0] col;
        logic                        wr, inten, along;
        along  = sh_options[gtf_pkg::OPT_ALONG];
        inten  = sh_options[gtf_pkg::OPT_INTEN];
        len    = along ? sh_height : sh_width;
        across = along ? sh_width : sh_height;
        if (len > gtf_pkg::MAX_SIZE)
            len = gtf_pkg::MAX_SIZE;
        lo = sh_options[gtf_pkg::OPT_WHOLE] ? 0 : sh_start;
        hi = sh_options[gtf_pkg::OPT_WHOLE] ? len : sh_goal;
        wr = (pos >= lo) && (pos < hi) && (pos < len) && (crs < across);

        // wrap rotates the line by half its length
        mid = len >> 1;
        e   = longint'(pos);
        if (sh_options[gtf_pkg::OPT_WRAP])
            e = (pos < mid) ? longint'(pos) + longint'(mid) : longint'(pos) - longint'(mid);
        col = gradient_color(e);

        // tiled address: 8x4 byte tiles for intensity, 4x4 two-plane tiles for color
        x = along ? crs : pos;
        y = along ? pos : crs;
        if (inten)
            off = (x & 7) + (y & 3) * 8 + ((x >> 3) + (y >> 2) * (sh_width >> 3)) * 32;
        else
            off = ((x >> 2) + (y >> 2) * (sh_width >> 2)) * 64 + (y & 3) * 8 + (x & 3) * 2;

        r.written     = wr;
        r.offset      = wr ? off[gtf_pkg::OFF_W-1:0] : '0;
        r.alpha       = (wr && !inten) ? col[7:0] : 8'd0;
        r.red         = wr ? col[31:24] : 8'd0;
        r.green       = (wr && !inten) ? col[23:16] : 8'd0;
        r.blue        = (wr && !inten) ? col[15:8] : 8'd0;
        r.single_byte = inten;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both streams and the config channel at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_texel_result want;
        item_taken = 1'b0;
        if (i_rst_n) begin
            // compare each result transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_texels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: result with nothing expected, expected none, %s0x%0h",
                                 $time, "actual ", m_axis_tdata);
                end else begin
                    want = expected_texels.pop_front();
                    check_field("written", want.written, m_axis_tdata[0]);
                    check_field("offset", want.offset, m_axis_tdata[22:1]);
                    check_field("alpha", want.alpha, m_axis_tdata[30:23]);
                    check_field("red", want.red, m_axis_tdata[38:31]);
                    check_field("green", want.green, m_axis_tdata[46:39]);
                    check_field("blue", want.blue, m_axis_tdata[54:47]);
                    check_field("single_byte", want.single_byte, m_axis_tuser);
                end
            end
            // predict every accepted request with the settings in force
            if (s_axis_tvalid && s_axis_tready) begin
                item_taken = 1'b1;
                expected_texels.push_back(predict_texel(s_axis_tdata[PW-1:0],
                                                        s_axis_tdata[2*PW-1:PW]));
                accepted_items++;
            end
            // track register writes in the shadow copy
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gtf_pkg::CFG_CURVE_KIND: sh_curve   = i_cfg_data[2:0];
                    gtf_pkg::CFG_START:      sh_start   = i_cfg_data[gtf_pkg::SIZE_W-1:0];
                    gtf_pkg::CFG_GOAL:       sh_goal    = i_cfg_data[gtf_pkg::SIZE_W-1:0];
                    gtf_pkg::CFG_COLOR_FROM: sh_from    = i_cfg_data;
                    gtf_pkg::CFG_COLOR_TO:   sh_to      = i_cfg_data;
                    gtf_pkg::CFG_OPTIONS:    sh_options = i_cfg_data[3:0];
                    gtf_pkg::CFG_TEX_WIDTH:  sh_width   = i_cfg_data[gtf_pkg::SIZE_W-1:0];
                    gtf_pkg::CFG_TEX_HEIGHT: sh_height  = i_cfg_data[gtf_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_texel_request req;
        // advance only when the slot is empty or its transaction just completed
        if (!s_axis_tvalid || item_taken) begin
            if (texel_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                req = texel_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(gtf_pkg::IN_TDATA_W-2*PW){1'b0}},
                                  req.cross_req, req.position};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_texel(input int unsigned pos, input int unsigned crs);
        t_texel_request req;
        req.position  = pos[PW-1:0];
        req.cross_req = crs[PW-1:0];
        texel_requests.push_back(req);
        issued_items++;
    endtask

    // Hold until every queued request went in and every result came out.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (accepted_items != issued_items || expected_texels.size() != 0);
    endtask

    task automatic write_reg(input gtf_pkg::t_cfg_idx idx,
                             input logic [gtf_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Load the whole register file; valid stays up between back-to-back writes.
    task automatic load_settings(input logic [2:0] curve, input int unsigned st,
                                 input int unsigned gl, input logic [31:0] from_c,
                                 input logic [31:0] to_c, input logic [3:0] opts,
                                 input int unsigned w, input int unsigned h);
        write_reg(gtf_pkg::CFG_CURVE_KIND, 32'(curve));
        write_reg(gtf_pkg::CFG_START, st);
        write_reg(gtf_pkg::CFG_GOAL, gl);
        write_reg(gtf_pkg::CFG_COLOR_FROM, from_c);
        write_reg(gtf_pkg::CFG_COLOR_TO, to_c);
        write_reg(gtf_pkg::CFG_OPTIONS, 32'(opts));
        write_reg(gtf_pkg::CFG_TEX_WIDTH, w);
        write_reg(gtf_pkg::CFG_TEX_HEIGHT, h);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_color();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One random setting followed by a burst of requests, most of them aimed
    // at the texture and the gradient ramp so the blend path stays busy.
    task automatic run_random_phase(input int n_items);
        logic [2:0]  curve;
        logic [3:0]  opts;
        int unsigned st, gl, a, b, w, h, len, across, pos, crs;
        curve = $urandom_range(7);
        opts  = $urandom_range(15);
        // sizes mostly multiples of eight; now and then any size from 8 to 2047
        w = ($urandom_range(7) == 0) ? $urandom_range(2047, 8) : 8 * $urandom_range(128, 1);
        h = ($urandom_range(7) == 0) ? $urandom_range(2047, 8) : 8 * $urandom_range(128, 1);
        len    = opts[gtf_pkg::OPT_ALONG] ? h : w;
        across = opts[gtf_pkg::OPT_ALONG] ? w : h;
        if (len > gtf_pkg::MAX_SIZE)
            len = gtf_pkg::MAX_SIZE;
        if (across > gtf_pkg::MAX_SIZE)
            across = gtf_pkg::MAX_SIZE;
        case ($urandom_range(9))
            0: begin
                st = $urandom_range(1024);
                gl = $urandom_range(1024);
            end
            1: begin
                st = $urandom_range(len);
                gl = ($urandom_range(1) == 0) ? 0 : st;
            end
            default: begin
                a  = $urandom_range(len);
                b  = $urandom_range(len);
                st = (a < b) ? a : b;
                gl = (a < b) ? b : a;
            end
        endcase
        load_settings(curve, st, gl, random_color(), random_color(), opts, w, h);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) < 7) begin
                if (gl > st && $urandom_range(1) == 0)
                    pos = $urandom_range((gl > 1023) ? 1023 : gl, (st > 1023) ? 1023 : st);
                else
                    pos = $urandom_range(len - 1);
                crs = $urandom_range(across - 1);
            end else begin
                pos = $urandom_range(1023);
                crs = $urandom_range(1023);
            end
            queue_texel(pos, crs);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct   = 37;
        recv_stall_pct = 81;

        // reset defaults: 8x8 texture, empty write range
        queue_texel(0, 0);
        queue_texel(7, 7);
        wait_idle();

        // full-size texture, whole line, black to white linear ramp
        load_settings(gtf_pkg::CURVE_LINEAR, 0, 1024, 32'h0000_0000, 32'hFFFF_FFFF,
                      O_WHOLE, 1024, 1024);
        queue_texel(0, 0);
        queue_texel(1023, 1023);
        queue_texel(512, 300);
        queue_texel(511, 0);
        wait_idle();

        // intensity format along t with wrap, ease-out curve
        load_settings(gtf_pkg::CURVE_OUT4, 100, 900, 32'h12345678, 32'hFEDCBA98,
                      O_INTEN | O_ALONG | O_WRAP, 1024, 1024);
        queue_texel(100, 5);
        queue_texel(899, 1023);
        queue_texel(1023, 7);
        queue_texel(0, 0);
        wait_idle();

        // goal below start and curve selector seven
        load_settings(3'd7, 200, 50, 32'hFF00_FF00, 32'h00FF_00FF, O_WHOLE, 256, 64);
        queue_texel(60, 1);
        queue_texel(49, 1);
        queue_texel(48, 1);
        queue_texel(199, 3);
        wait_idle();

        // goal at zero with wrap: every index takes the end color
        load_settings(gtf_pkg::CURVE_POW2, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                      O_WHOLE | O_WRAP, 64, 64);
        queue_texel(0, 0);
        queue_texel(5, 2);
        wait_idle();

        // oversize width overflows the offset; height not a multiple of eight
        load_settings(gtf_pkg::CURVE_POW16, 0, 1024, 32'h0102_0304, 32'hF0E0_D0C0,
                      O_WHOLE, 2047, 1020);
        queue_texel(1023, 1019);
        queue_texel(1023, 1020);
        queue_texel(1000, 1019);
        wait_idle();

        // oversize height along t: line length capped
        load_settings(gtf_pkg::CURVE_POW8, 3, 1024, 32'h8080_8080, 32'h7F7F_7F7F,
                      O_ALONG | O_WHOLE | O_INTEN, 1020, 2047);
        queue_texel(1023, 1019);
        queue_texel(600, 1019);
        wait_idle();

        // random settings under three idling profiles
        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: begin
                    send_gap_pct   = 37;
                    recv_stall_pct = 81;
                end
                1: begin
                    send_gap_pct   = 81;
                    recv_stall_pct = 37;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        // drain, then give stray results a chance to show up
        wait_idle();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (expected_texels.size() != 0) begin
            mismatches++;
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, expected_texels.size());
        end

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
